### rtl/interval_booking_table_macros.svh
// Assertion macros used by the interval booking table RTL.
`ifndef INTERVAL_BOOKING_TABLE_MACROS_SVH
`define INTERVAL_BOOKING_TABLE_MACROS_SVH

`ifndef SYNTHESIS

// The condition holds at every clock edge outside reset.
`define IBT_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("interval booking table: invariant violated");

// The consequent holds in the same cycle as the antecedent.
`define IBT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("interval booking table: implication violated");

// The consequent holds in the cycle after the antecedent.
`define IBT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("interval booking table: next-cycle check violated");

`else

`define IBT_ASSERT(lbl, cond)
`define IBT_ASSERT_IMP(lbl, ante, cons)
`define IBT_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### rtl/ibt_pkg.sv
// Types and constants shared by the interval booking table files.
package ibt_pkg;

  // Default sizing of the table.
  localparam int CAPACITY_DEF  = 64;
  localparam int TIME_BITS_DEF = 32;

  // Width of the span fields on the request channel.
  localparam int SPAN_W = 32;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_BOOKED  = 2'd0,
    STATUS_OVERLAP = 2'd1,
    STATUS_FULL    = 2'd2
  } status_t;

  // Request sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

### rtl/ibt_if.sv
// Valid/ready channel interfaces for booking requests and results.
interface ibt_req_if;
  logic                       valid;
  logic                       ready;
  logic [ibt_pkg::SPAN_W-1:0] span_start;
  logic [ibt_pkg::SPAN_W-1:0] span_end;

  modport source (output valid, output span_start, output span_end, input ready);
  modport sink (input valid, input span_start, input span_end, output ready);
endinterface

interface ibt_rsp_if;
  logic             valid;
  logic             ready;
  logic             accepted;
  ibt_pkg::status_t status;

  modport source (output valid, output accepted, output status, input ready);
  modport sink (input valid, input accepted, input status, output ready);
endinterface

### rtl/interval_booking_table.sv
// Interval booking table: reserves half-open time spans and refuses overlapping ones.
//
// Each request item [span_start, span_end) is compared against every stored
// span by reading the span memory one entry per cycle through its single read
// port into a read data register; a finish step then, once the output register
// is free, writes back a booked span and loads the result. One request is
// worked on at a time; a finished result waits in an output register while
// the next request is accepted, from the cycle after the result is loaded.
// Status is booked, overlap (which wins over full) or full. Empty or reversed
// spans overlap nothing and are stored as given.
// Entries past the fill count are never read, so the memory needs no clearing.
module interval_booking_table #(
  parameter int CAPACITY  = ibt_pkg::CAPACITY_DEF,
  parameter int TIME_BITS = ibt_pkg::TIME_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ibt_req_if.sink    in_req,
  ibt_rsp_if.source  out_rsp
);
  import ibt_pkg::*;

`include "interval_booking_table_macros.svh"

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int ENT_W = 2 * TIME_BITS;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // Span memory: start in the upper half, end in the lower half.
  logic [ENT_W-1:0]     span_mem [CAPACITY];
  logic [ENT_W-1:0]     rd_data_r;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     issue_r, issue_nxt;
  logic                 rd_vld_r, rd_vld_nxt;
  logic                 clash_r, clash_nxt;
  logic [TIME_BITS-1:0] start_r, start_nxt;
  logic [TIME_BITS-1:0] end_r, end_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_accepted_r, out_accepted_nxt;
  status_t              out_status_r, out_status_nxt;

  logic                 in_ready;
  logic                 in_fire;
  logic                 rd_en;
  logic                 finish_fire;
  logic                 book;
  logic                 wr_en;
  logic                 slot_free;
  logic                 scan_done;
  logic                 hit;
  logic [TIME_BITS-1:0] stored_start;
  logic [TIME_BITS-1:0] stored_end;

  assign in_fire   = in_req.valid && in_ready;
  assign slot_free = !out_valid_r || out_rsp.ready;
  assign scan_done = (issue_r == count_r) && !rd_vld_r;
  assign book      = !clash_r && (count_r != CAP_CNT);
  assign wr_en     = finish_fire && book;

  // Next state of the request sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_done) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control decode of the sequencer state.
  always_comb begin
    in_ready    = 1'b0;
    rd_en       = 1'b0;
    finish_fire = 1'b0;
    case (state_r)
      ST_IDLE:   in_ready    = 1'b1;
      ST_SCAN:   rd_en       = (issue_r != count_r);
      ST_FINISH: finish_fire = slot_free;
      default:   in_ready    = 1'b0;
    endcase
  end

  // Overlap test: max(starts) < min(ends) split into four parallel compares.
  assign stored_start = rd_data_r[ENT_W-1:TIME_BITS];
  assign stored_end   = rd_data_r[TIME_BITS-1:0];
  assign hit = (stored_start < stored_end) && (start_r < end_r) &&
               (stored_start < end_r) && (start_r < stored_end);

  // Datapath next values.
  always_comb begin
    count_nxt        = count_r;
    issue_nxt        = issue_r;
    rd_vld_nxt       = rd_en;
    clash_nxt        = clash_r;
    start_nxt        = start_r;
    end_nxt          = end_r;
    out_valid_nxt    = out_valid_r;
    out_accepted_nxt = out_accepted_r;
    out_status_nxt   = out_status_r;

    if (in_fire) begin
      start_nxt = TIME_BITS'(in_req.span_start);
      end_nxt   = TIME_BITS'(in_req.span_end);
      issue_nxt = '0;
      clash_nxt = 1'b0;
    end
    if (rd_en) issue_nxt = issue_r + CNT_W'(1);
    if (rd_vld_r && hit) clash_nxt = 1'b1;

    if (out_valid_r && out_rsp.ready) out_valid_nxt = 1'b0;
    if (finish_fire) begin
      out_valid_nxt    = 1'b1;
      out_accepted_nxt = book;
      if (clash_r) begin
        out_status_nxt = STATUS_OVERLAP;
      end else if (book) begin
        out_status_nxt = STATUS_BOOKED;
      end else begin
        out_status_nxt = STATUS_FULL;
      end
      if (book) count_nxt = count_r + CNT_W'(1);
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    issue_r        <= issue_nxt;
    clash_r        <= clash_nxt;
    start_r        <= start_nxt;
    end_r          <= end_nxt;
    out_accepted_r <= out_accepted_nxt;
    out_status_r   <= out_status_nxt;
  end

  // Span memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) span_mem[count_r[IDX_W-1:0]] <= {start_r, end_r};
    if (rd_en) rd_data_r <= span_mem[issue_r[IDX_W-1:0]];
  end

  // Channel outputs.
  assign in_req.ready     = in_ready;
  assign out_rsp.valid    = out_valid_r;
  assign out_rsp.accepted = out_accepted_r;
  assign out_rsp.status   = out_status_r;

  // Checks on the sequencer and the fill count.
  `IBT_ASSERT(a_count_bound, count_r <= CAP_CNT)
  `IBT_ASSERT_NEXT(a_accept_scans, in_fire, state_r == ST_SCAN)
  `IBT_ASSERT_NEXT(a_book_counts, wr_en, count_r == $past(count_r) + CNT_W'(1))
  `IBT_ASSERT_IMP(a_rw_apart, wr_en, !rd_en && !rd_vld_r)
  `IBT_ASSERT_IMP(a_result_code, out_valid_r,
                  out_accepted_r == (out_status_r == STATUS_BOOKED))

endmodule

### verif/ibt_booking_checker.sv
// Checker that predicts and compares the interval booking table's results.
`timescale 1ns / 1ps
module ibt_booking_checker #(
  parameter int CAPACITY  = ibt_pkg::CAPACITY_DEF,
  parameter int TIME_BITS = ibt_pkg::TIME_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       req_valid,
  input  logic                       req_ready,
  input  logic [ibt_pkg::SPAN_W-1:0] req_start,
  input  logic [ibt_pkg::SPAN_W-1:0] req_end,
  input  logic                       rsp_valid,
  input  logic                       rsp_ready,
  input  logic                       rsp_accepted,
  input  ibt_pkg::status_t           rsp_status,
  output int                         mismatch_count,
  output int                         awaited_count,
  output int                         booked_count,
  output int                         overlap_count,
  output int                         full_count
);
  import ibt_pkg::*;

  typedef struct packed {
    logic    accepted;
    status_t status;
  } booking_t;

  // Bits above TIME_BITS play no part in the comparison.
  localparam logic [SPAN_W-1:0] SPAN_MASK = {SPAN_W{1'b1}} >> (SPAN_W - TIME_BITS);

  logic [SPAN_W-1:0] held_starts [CAPACITY];
  logic [SPAN_W-1:0] held_ends [CAPACITY];
  int                held_count;
  booking_t          awaited_bookings [$];

  // Tries to reserve [lo, hi) against the held spans and updates the table.
  function automatic booking_t reserve_span(input logic [SPAN_W-1:0] lo,
                                            input logic [SPAN_W-1:0] hi);
    booking_t          verdict;
    logic              clash;
    logic [SPAN_W-1:0] later_start;
    logic [SPAN_W-1:0] earlier_end;
    clash = 1'b0;
    for (int i = 0; i < held_count; i++) begin
      later_start = (held_starts[i] > lo) ? held_starts[i] : lo;
      earlier_end = (held_ends[i] < hi) ? held_ends[i] : hi;
      if (later_start < earlier_end) begin
        clash = 1'b1;
      end
    end
    if (clash) begin
      verdict = '{accepted: 1'b0, status: STATUS_OVERLAP};
    end else if (held_count >= CAPACITY) begin
      verdict = '{accepted: 1'b0, status: STATUS_FULL};
    end else begin
      held_starts[held_count] = lo;
      held_ends[held_count]   = hi;
      held_count++;
      verdict = '{accepted: 1'b1, status: STATUS_BOOKED};
    end
    return verdict;
  endfunction

  // Results are matched first, since a request taken at the same edge is newer.
  always @(posedge clk) begin
    booking_t want;
    if (!rst_n) begin
      held_count     = 0;
      mismatch_count = 0;
      booked_count   = 0;
      overlap_count  = 0;
      full_count     = 0;
      awaited_bookings.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        case (rsp_status)
          STATUS_BOOKED:  booked_count++;
          STATUS_OVERLAP: overlap_count++;
          STATUS_FULL:    full_count++;
          default: ;
        endcase
        if (awaited_bookings.size() == 0) begin
          $error("result with none awaited: accepted %0d, status %0d",
                 rsp_accepted, rsp_status);
          mismatch_count++;
        end else begin
          want = awaited_bookings.pop_front();
          if (rsp_accepted !== want.accepted) begin
            $error("accepted: expected %0d, actual %0d", want.accepted, rsp_accepted);
            mismatch_count++;
          end
          if (rsp_status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp_status);
            mismatch_count++;
          end
        end
      end
      if (req_valid && req_ready) begin
        awaited_bookings.insert(awaited_bookings.size(),
                                reserve_span(req_start & SPAN_MASK, req_end & SPAN_MASK));
      end
    end
    awaited_count = awaited_bookings.size();
  end

endmodule

### verif/tb_interval_booking_table.sv
// Top of the interval booking table testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_interval_booking_table;
  import ibt_pkg::*;

  localparam int CAPACITY        = CAPACITY_DEF;
  localparam int TIME_BITS       = TIME_BITS_DEF;
  localparam int RANDOM_REQUESTS = 440;
  localparam int STALL_LIMIT     = 2000;
  localparam int SETTLE_CYCLES   = CAPACITY + 16;

  typedef struct {
    logic [SPAN_W-1:0] lo;
    logic [SPAN_W-1:0] hi;
  } span_t;

  logic      clk;
  logic      rst_n;
  ibt_req_if req_if ();
  ibt_rsp_if rsp_if ();

  bit        steady;
  span_t     sent_spans [$];
  int        quiet_cycles;
  int        mismatch_count;
  int        awaited_count;
  int        booked_count;
  int        overlap_count;
  int        full_count;

  interval_booking_table #(
    .CAPACITY  (CAPACITY),
    .TIME_BITS (TIME_BITS)
  ) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_if),
    .out_rsp (rsp_if)
  );

  ibt_booking_checker #(
    .CAPACITY  (CAPACITY),
    .TIME_BITS (TIME_BITS)
  ) booking_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req_if.valid),
    .req_ready      (req_if.ready),
    .req_start      (req_if.span_start),
    .req_end        (req_if.span_end),
    .rsp_valid      (rsp_if.valid),
    .rsp_ready      (rsp_if.ready),
    .rsp_accepted   (rsp_if.accepted),
    .rsp_status     (rsp_if.status),
    .mismatch_count (mismatch_count),
    .awaited_count  (awaited_count),
    .booked_count   (booked_count),
    .overlap_count  (overlap_count),
    .full_count     (full_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side: stalls at random except during the steady stretch.
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      rsp_if.ready <= steady || ($urandom_range(0, 99) >= 30);
    end
  end

  // Ends the run if no item moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one request item and holds it until the block takes it.
  task automatic offer_span(input logic [SPAN_W-1:0] lo, input logic [SPAN_W-1:0] hi);
    if (!steady && $urandom_range(0, 99) < 30) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.span_start <= lo;
    req_if.span_end   <= hi;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    sent_spans.insert(sent_spans.size(), span_t'{lo: lo, hi: hi});
  endtask

  // Stops sending until every awaited result has come back.
  task automatic drain_results();
    req_if.valid <= 1'b0;
    do @(negedge clk); while (awaited_count != 0);
    @(posedge clk);
  endtask

  // Mostly short fresh spans and near copies of earlier ones, plus odd shapes.
  task automatic pick_span(output logic [SPAN_W-1:0] lo, output logic [SPAN_W-1:0] hi);
    int    pick;
    span_t earlier;
    pick = $urandom_range(0, 99);
    if (pick < 40 || sent_spans.size() == 0) begin
      lo = $urandom;
      hi = lo + $urandom_range(1, 4096);
    end else if (pick < 65) begin
      earlier = sent_spans[$urandom_range(0, sent_spans.size() - 1)];
      lo = earlier.lo + $urandom_range(0, 8) - 4;
      hi = lo + $urandom_range(1, 64);
    end else if (pick < 78) begin
      // Empty or reversed span.
      lo = $urandom;
      hi = lo - $urandom_range(0, 255);
    end else if (pick < 85) begin
      lo = $urandom;
      hi = $urandom;
    end else begin
      // Spans hugging either end of the time range.
      lo = $urandom_range(0, 1) ? $urandom_range(0, 15) : ~$urandom_range(0, 15);
      hi = $urandom_range(0, 1) ? $urandom_range(0, 15) : ~$urandom_range(0, 15);
    end
  endtask

  initial begin
    logic [SPAN_W-1:0] lo;
    logic [SPAN_W-1:0] hi;
    req_if.valid      = 1'b0;
    req_if.span_start = '0;
    req_if.span_end   = '0;
    steady            = 1'b0;
    rst_n             = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Empty and reversed spans at the range limits are stored as given.
    offer_span(32'h0000_0000, 32'h0000_0000);
    offer_span(32'hFFFF_FFFF, 32'h0000_0000);
    // Spans that only touch end to start do not overlap.
    offer_span(32'd10, 32'd20);
    offer_span(32'd20, 32'd30);
    offer_span(32'd0, 32'd10);
    // Inner, covering and straddling overlaps.
    offer_span(32'd15, 32'd16);
    offer_span(32'd5, 32'd25);
    offer_span(32'd19, 32'd21);
    // An empty span inside a stored one still overlaps nothing.
    offer_span(32'd25, 32'd25);
    offer_span(32'd30, 32'd30);
    offer_span(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    offer_span(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    offer_span(32'h8000_0000, 32'h8000_0001);
    offer_span(32'hAAAA_AAAA, 32'h5555_5555);
    offer_span(32'h5555_5555, 32'hAAAA_AAAA);
    offer_span(32'h6000_0000, 32'h6000_0010);
    drain_results();

    // Random part: the table fills, then full and overlap refusals take over.
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == 100) begin
        drain_results();
      end
      steady <= (n >= 150 && n < 250);
      pick_span(lo, hi);
      offer_span(lo, hi);
    end
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d booking requests, directed edge and empty spans first, then random.",
             sent_spans.size());
    $display("Results: %0d booked, %0d refused on overlap, %0d refused with the table full.",
             booked_count, overlap_count, full_count);
    if (mismatch_count == 0 && awaited_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
